// ===== hw/rtl/fractional_delay_line_assert.svh =====
// Assertion macros for the delay line RTL.
`ifndef FRACTIONAL_DELAY_LINE_ASSERT_SVH
`define FRACTIONAL_DELAY_LINE_ASSERT_SVH

// Same-cycle implication.
`define FDL_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define FDL_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/fdl_pkg.sv =====
package fdl_pkg;

   localparam int MAX_LENGTH_DEF    = 1024;
   localparam int FRACTION_BITS_DEF = 8;

   localparam int SAMPLE_W = 16;
   localparam int LEN_W    = 11;
   localparam int DELAY_W  = 18;
   localparam int CSR_W    = 18;
   localparam int CSR_IDX_W = 1;

   localparam int LEN_RESET  = 1024;
   localparam int MIN_LENGTH = 2;

   // cycles for the derived config registers to settle after a write
   localparam int CFG_SETTLE   = 3;
   localparam int CFG_SETTLE_W = 2;

   localparam logic [CSR_IDX_W-1:0] REG_LINE_LENGTH = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_DELAY_Q8    = 1'b1;

endpackage

// ===== hw/rtl/fractional_delay_line.sv =====
// Fractional delay line, linear interpolation.
// req channel: one 16-bit signed sample per beat (req_valid / req_stall).
// rsp channel: one interpolated 16-bit signed sample per accepted req beat,
//   in order (rsp_valid / rsp_stall).
// csr port: csr_we writes csr_wdata to register csr_index (0 line_length,
//   1 delay_q8). Write only while idle; the input stalls after each write
//   while the clamped length/delay and wrap offset settle.
// Path: an accepted sample passes the memory read registers, the product
//   register and the output register before rsp_valid rises for it.
// Throughput: one beat per cycle unless req_stall is high; set by the two
//   sample memories (one write, one neighbor read port each).
// Reset: synchronous, active high. After reset a clearing pass writes zero to
//   all MAX_LENGTH entries, one per cycle; req is stalled until the pass
//   ends. CSR writes are taken during the pass.
// Stall: when rsp_stall holds, the output register keeps its beat; the two
//   stages behind it keep filling, and req_stall rises only once all are full.
module fractional_delay_line #(
   parameter int MAX_LENGTH    = fdl_pkg::MAX_LENGTH_DEF,
   parameter int FRACTION_BITS = fdl_pkg::FRACTION_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic signed [fdl_pkg::SAMPLE_W-1:0]   req_sample_in,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [fdl_pkg::SAMPLE_W-1:0]   rsp_sample_out,
   input  logic                                  csr_we,
   input  logic        [fdl_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic        [fdl_pkg::CSR_W-1:0]      csr_wdata
);

   localparam int SW = fdl_pkg::SAMPLE_W;
   localparam int AW = $clog2(MAX_LENGTH);
   localparam int LW = $clog2(MAX_LENGTH + 1);
   localparam int FB = FRACTION_BITS;
   localparam int DW = AW + FB;
   localparam int KW = (LW > fdl_pkg::LEN_W) ? LW : fdl_pkg::LEN_W;
   localparam int CW = (DW > fdl_pkg::DELAY_W) ? DW : fdl_pkg::DELAY_W;
   localparam int PW = SW + 2 + FB;

   // ---------------------------------------------------------------
   // Configuration: raw registers, then three settle stages
   // ---------------------------------------------------------------
   logic [fdl_pkg::LEN_W-1:0]   len_raw_ff;
   logic [fdl_pkg::DELAY_W-1:0] dly_raw_ff;
   logic [fdl_pkg::CFG_SETTLE_W-1:0] settle_ff, settle_in;
   logic [LW-1:0] len_ff, len_in;
   logic [AW-1:0] len_m1_ff, len_m1_in;
   logic [DW-1:0] dly_ff, dly_in;
   logic [DW:0]   comp_ff, comp_in;   // len*2^F - delay, wrap offset

   always_ff @(posedge clock) begin
      if (reset) begin
         len_raw_ff <= fdl_pkg::LEN_W'(fdl_pkg::LEN_RESET);
         dly_raw_ff <= '0;
         settle_ff  <= fdl_pkg::CFG_SETTLE_W'(fdl_pkg::CFG_SETTLE);
      end else begin
         if (csr_we) begin
            case (csr_index)
               fdl_pkg::REG_LINE_LENGTH: len_raw_ff <= csr_wdata[fdl_pkg::LEN_W-1:0];
               fdl_pkg::REG_DELAY_Q8:    dly_raw_ff <= csr_wdata[fdl_pkg::DELAY_W-1:0];
               default: ;
            endcase
         end
         settle_ff <= settle_in;
      end
   end

   always_comb begin
      if (csr_we)
         settle_in = fdl_pkg::CFG_SETTLE_W'(fdl_pkg::CFG_SETTLE);
      else if (settle_ff != '0)
         settle_in = settle_ff - 1'b1;
      else
         settle_in = settle_ff;
   end

   // stage 1: clamp length to [2, MAX_LENGTH]
   logic [KW-1:0] len_raw_x;
   always_comb begin
      len_raw_x = KW'(len_raw_ff);
      if (len_raw_x < KW'(fdl_pkg::MIN_LENGTH))
         len_in = LW'(fdl_pkg::MIN_LENGTH);
      else if (len_raw_x > KW'(MAX_LENGTH))
         len_in = LW'(MAX_LENGTH);
      else
         len_in = len_raw_x[LW-1:0];
   end

   // stage 2: saturate delay at (len-1)*2^F
   logic [CW-1:0] max_dly_x, dly_raw_x, dly_sel;
   always_comb begin
      len_m1_in = AW'(len_ff - LW'(1));
      max_dly_x = CW'(DW'(len_m1_in) << FB);
      dly_raw_x = CW'(dly_raw_ff);
      dly_sel   = (dly_raw_x > max_dly_x) ? max_dly_x : dly_raw_x;
      dly_in    = dly_sel[DW-1:0];
   end

   // stage 3: offset added when the read point wraps below zero
   assign comp_in = ((DW + 1)'(len_ff) << FB) - (DW + 1)'(dly_ff);

   always_ff @(posedge clock) begin
      len_ff    <= len_in;
      len_m1_ff <= len_m1_in;
      dly_ff    <= dly_in;
      comp_ff   <= comp_in;
   end

   // ---------------------------------------------------------------
   // Clearing pass after reset
   // ---------------------------------------------------------------
   logic          clr_ff, clr_in;
   logic [AW-1:0] clr_cnt_ff, clr_cnt_in;

   assign clr_in     = clr_ff && (clr_cnt_ff != AW'(MAX_LENGTH - 1));
   assign clr_cnt_in = clr_cnt_ff + 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff     <= 1'b1;
         clr_cnt_ff <= '0;
      end else if (clr_ff) begin
         clr_ff     <= clr_in;
         clr_cnt_ff <= clr_cnt_in;
      end
   end

   // ---------------------------------------------------------------
   // Pipeline flow control
   // ---------------------------------------------------------------
   logic rsp_valid_ff;
   logic v1_ff, v2_ff;
   logic out_rdy, s2_rdy, s1_rdy, req_fire;

   assign out_rdy   = !rsp_valid_ff || !rsp_stall;
   assign s2_rdy    = !v2_ff || out_rdy;
   assign s1_rdy    = !v1_ff || s2_rdy;
   assign req_stall = clr_ff || (settle_ff != '0) || !s1_rdy;
   assign req_fire  = req_valid && !req_stall;

   // ---------------------------------------------------------------
   // Stage 0: write position, read point, memory access
   // ---------------------------------------------------------------
   logic [AW-1:0] wp_ff, wp_in;
   logic [DW-1:0] wpos, pos, pos_alt;
   logic [DW:0]   pos_diff;
   logic [AW-1:0] rd_i, rd_j;
   logic [FB-1:0] frac;

   always_comb begin
      wpos     = DW'(wp_ff) << FB;
      pos_diff = {1'b0, wpos} - {1'b0, dly_ff};
      pos_alt  = DW'((DW + 1)'(wpos) + comp_ff);
      pos      = pos_diff[DW] ? pos_alt : pos_diff[DW-1:0];
      rd_i     = pos[DW-1:FB];
      frac     = pos[FB-1:0];
      rd_j     = (rd_i == len_m1_ff) ? '0 : rd_i + 1'b1;
   end

   // advance on each beat; restart if a shorter length left it out of range
   always_comb begin
      if (req_fire)
         wp_in = (wp_ff == len_m1_ff) ? '0 : wp_ff + 1'b1;
      else if (wp_ff > len_m1_ff)
         wp_in = '0;
      else
         wp_in = wp_ff;
   end

   always_ff @(posedge clock) begin
      if (reset)
         wp_ff <= '0;
      else
         wp_ff <= wp_in;
   end

   // two copies of the store, one per neighbor read
   logic signed [SW-1:0] mem_a [MAX_LENGTH];
   logic signed [SW-1:0] mem_b [MAX_LENGTH];
   logic                 wr_en;
   logic [AW-1:0]        wr_addr;
   logic signed [SW-1:0] wr_data;

   assign wr_en   = clr_ff || req_fire;
   assign wr_addr = clr_ff ? clr_cnt_ff : wp_ff;
   assign wr_data = clr_ff ? '0 : req_sample_in;

   logic signed [SW-1:0] rd_a_ff, rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_a[wr_addr] <= wr_data;
         mem_b[wr_addr] <= wr_data;
      end
      if (s1_rdy) begin
         rd_a_ff <= mem_a[rd_i];
         rd_b_ff <= mem_b[rd_j];
      end
   end

   // ---------------------------------------------------------------
   // Stage 1: forward the same-edge write, multiply the difference
   // ---------------------------------------------------------------
   logic [FB-1:0]        f1_ff;
   logic                 hit_a1_ff, hit_b1_ff;
   logic signed [SW-1:0] smp1_ff;

   always_ff @(posedge clock) begin
      if (reset)
         v1_ff <= 1'b0;
      else if (s1_rdy)
         v1_ff <= req_fire;
   end

   always_ff @(posedge clock) begin
      if (s1_rdy) begin
         f1_ff     <= frac;
         hit_a1_ff <= (rd_i == wp_ff);
         hit_b1_ff <= (rd_j == wp_ff);
         smp1_ff   <= req_sample_in;
      end
   end

   logic signed [SW-1:0] a1, b1;
   logic signed [SW:0]   diff1;
   logic signed [FB:0]   f1_s;
   logic signed [PW-1:0] prod_in;

   always_comb begin
      a1      = hit_a1_ff ? smp1_ff : rd_a_ff;
      b1      = hit_b1_ff ? smp1_ff : rd_b_ff;
      diff1   = (SW + 1)'(b1) - (SW + 1)'(a1);
      f1_s    = $signed({1'b0, f1_ff});
      prod_in = PW'(diff1 * f1_s);
   end

   logic signed [SW-1:0] a2_ff;
   logic signed [PW-1:0] prod2_ff;

   always_ff @(posedge clock) begin
      if (reset)
         v2_ff <= 1'b0;
      else if (s2_rdy)
         v2_ff <= v1_ff;
   end

   always_ff @(posedge clock) begin
      if (s2_rdy) begin
         a2_ff    <= a1;
         prod2_ff <= prod_in;
      end
   end

   // ---------------------------------------------------------------
   // Stage 2: round half up, add base sample
   // ---------------------------------------------------------------
   logic signed [PW-1:0] rnd2;
   logic signed [PW-1:0] res_wide;
   logic signed [SW-1:0] rsp_sample_out_ff, rsp_sample_out_in;

   always_comb begin
      rnd2              = (prod2_ff + (PW'(1) << (FB - 1))) >>> FB;
      res_wide          = PW'(a2_ff) + rnd2;
      rsp_sample_out_in = res_wide[SW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset)
         rsp_valid_ff <= 1'b0;
      else if (out_rdy)
         rsp_valid_ff <= v2_ff;
   end

   always_ff @(posedge clock) begin
      if (out_rdy && v2_ff)
         rsp_sample_out_ff <= rsp_sample_out_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = rsp_sample_out_ff;

   // ---------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------
`include "fractional_delay_line_assert.svh"

   `FDL_ASSERT_NOW(a_wp_in_range, clock, reset, req_fire, wp_ff <= len_m1_ff,
      "write position beyond length")
   `FDL_ASSERT_NOW(a_rd_in_range, clock, reset, req_fire, rd_i <= len_m1_ff,
      "read index beyond length")
   `FDL_ASSERT_NOW(a_nbr_wrap, clock, reset, req_fire,
      (rd_j == AW'(rd_i + 1'b1)) || (rd_j == '0), "upper neighbor not adjacent")
   `FDL_ASSERT_NEXT(a_s2_hold, clock, reset, v2_ff && !out_rdy,
      v2_ff && $stable(prod2_ff), "stalled stage lost its beat")

endmodule

// ===== tb/tb_top.sv =====
module tb_top;

   // Depth and fraction of the line under test; the class below uses them too.
   localparam int LINE_MAX  = fdl_pkg::MAX_LENGTH_DEF;
   localparam int FRAC      = fdl_pkg::FRACTION_BITS_DEF;
   localparam int ONE_Q     = 1 << FRAC;
   localparam int LEN_FIELD_MAX   = (1 << fdl_pkg::LEN_W) - 1;
   localparam int DELAY_FIELD_MAX = (1 << fdl_pkg::DELAY_W) - 1;

   // Random part size, receiver hold length, hard stop.
   localparam int RANDOM_BEATS = 900;
   localparam int LONG_HOLD    = 80;
   localparam int RUN_LIMIT    = 3_000_000;

   typedef logic signed [fdl_pkg::SAMPLE_W-1:0] sample_type;

   // ---------------------------------------------------------------------
   // Scoreboard: keeps its own copy of the line (samples, write pointer,
   // both registers), computes the interpolated output for every accepted
   // req beat and checks rsp beats against them in order.
   // ---------------------------------------------------------------------
   class delay_line_checker;
      sample_type                   history [LINE_MAX];
      int unsigned                  wr_pos;
      logic [fdl_pkg::LEN_W-1:0]    length_reg;
      logic [fdl_pkg::DELAY_W-1:0]  delay_reg;
      sample_type                   expected_q [$];
      int                           mismatches;
      int                           checked;

      function new();
         foreach (history[k]) history[k] = '0;
         wr_pos     = 0;
         length_reg = fdl_pkg::LEN_RESET;
         delay_reg  = '0;
         mismatches = 0;
         checked    = 0;
      endfunction

      function void set_register(logic [fdl_pkg::CSR_IDX_W-1:0] idx,
                                 logic [fdl_pkg::CSR_W-1:0] value);
         if (idx == fdl_pkg::REG_LINE_LENGTH)
            length_reg = value[fdl_pkg::LEN_W-1:0];
         else if (idx == fdl_pkg::REG_DELAY_Q8)
            delay_reg = value[fdl_pkg::DELAY_W-1:0];
      endfunction

      // Write the sample, then interpolate between the two neighbors that
      // sit the (clamped) delay behind the write pointer. Round half up.
      function void take_sample(sample_type s);
         int unsigned len, max_dly, dly, wq, pos, lo, hi, frac;
         int          acc;
         len = length_reg;
         if (len < fdl_pkg::MIN_LENGTH) len = fdl_pkg::MIN_LENGTH;
         if (len > LINE_MAX)   len = LINE_MAX;
         max_dly = (len - 1) * ONE_Q;
         dly     = (delay_reg > max_dly) ? max_dly : delay_reg;
         // pointer left beyond a shortened line restarts at zero
         if (wr_pos >= len) wr_pos = 0;
         history[wr_pos] = s;
         wq   = wr_pos * ONE_Q;
         pos  = (wq >= dly) ? wq - dly : wq + len * ONE_Q - dly;
         lo   = pos >> FRAC;
         frac = pos & (ONE_Q - 1);
         hi   = (lo + 1 >= len) ? 0 : lo + 1;
         acc  = int'(history[lo]) * int'(ONE_Q - frac) + int'(history[hi]) * int'(frac)
                + (ONE_Q / 2);
         expected_q.push_back(sample_type'(acc >>> FRAC));
         wr_pos = (wr_pos + 1 >= len) ? 0 : wr_pos + 1;
      endfunction

      function void check_output(sample_type actual);
         sample_type want;
         if (expected_q.size() == 0) begin
            $error("sample_out: beat with nothing expected, got %0d", actual);
            mismatches++;
            return;
         end
         want = expected_q.pop_front();
         checked++;
         if (actual !== want) begin
            $error("sample_out: expected %0d, got %0d", want, actual);
            mismatches++;
         end
      endfunction

      function int outstanding();
         return expected_q.size();
      endfunction
   endclass

   // ---------------------------------------------------------------------
   // DUT hookup
   // ---------------------------------------------------------------------
   logic                           clock;
   logic                           reset;
   logic                           req_valid;
   logic                           req_stall;
   sample_type                     req_sample_in;
   logic                           rsp_valid;
   logic                           rsp_stall;
   sample_type                     rsp_sample_out;
   logic                           csr_we;
   logic [fdl_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [fdl_pkg::CSR_W-1:0]      csr_wdata;

   fractional_delay_line DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_sample_in  (req_sample_in),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_sample_out (rsp_sample_out),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   delay_line_checker chk;

   // sender shaping
   int burst_left;
   int gap_max;
   int beats_sent;
   // long receiver holds: main asks, the receiver process counts them off
   int hold_requests;
   int holds_done;

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // ---------------------------------------------------------------------
   // Drivers. All inputs move on the falling edge; handshakes are sampled
   // on the rising edge. Tasks are entered and left on a falling edge.
   // ---------------------------------------------------------------------

   // One req beat. Between bursts valid drops for a random gap; inside a
   // burst it stays high so back-to-back beats go out with no bubble.
   task automatic send_sample(sample_type s);
      int gap;
      if (burst_left == 0) begin
         gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      req_valid     <= 1'b1;
      req_sample_in <= s;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      chk.take_sample(s);
      beats_sent++;
      burst_left--;
      @(negedge clock);
   endtask

   // Let every expected output come back, then wait on with req idle so
   // the line is truly quiet before a register write.
   task automatic wait_idle();
      req_valid <= 1'b0;
      burst_left = 0;
      while (chk.outstanding() != 0) @(negedge clock);
      repeat (6) @(negedge clock);
   endtask

   // Register writes, back to back when both are written. csr_we only
   // drops after the last one.
   task automatic configure(bit do_len, int unsigned len, bit do_dly, int unsigned dly);
      if (do_len) begin
         csr_we    <= 1'b1;
         csr_index <= fdl_pkg::REG_LINE_LENGTH;
         csr_wdata <= fdl_pkg::CSR_W'(len);
         chk.set_register(fdl_pkg::REG_LINE_LENGTH, fdl_pkg::CSR_W'(len));
         @(negedge clock);
      end
      if (do_dly) begin
         csr_we    <= 1'b1;
         csr_index <= fdl_pkg::REG_DELAY_Q8;
         csr_wdata <= fdl_pkg::CSR_W'(dly);
         chk.set_register(fdl_pkg::REG_DELAY_Q8, fdl_pkg::CSR_W'(dly));
         @(negedge clock);
      end
      csr_we <= 1'b0;
   endtask

   // Sample mix: rails, near-zero, full random.
   function automatic sample_type pick_sample();
      case ($urandom_range(0, 9))
         0:       return sample_type'(16'sh7FFF);
         1:       return sample_type'(16'sh8000);
         2:       return sample_type'(int'($urandom_range(0, 64)) - 32);
         default: return sample_type'($urandom);
      endcase
   endfunction

   // ---------------------------------------------------------------------
   // Output monitor
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         chk.check_output(rsp_sample_out);
   end

   // ---------------------------------------------------------------------
   // Receiver: stalls in stretches of differing character. A pending long
   // hold request preempts the pattern and keeps rsp_stall high for
   // the long hold length so the pipe fills and req_stall has to rise.
   // ---------------------------------------------------------------------
   initial begin : rsp_backpressure
      int mode;
      int stretch;
      int cyc;
      rsp_stall = 1'b0;
      cyc = 0;
      forever begin
         mode    = $urandom_range(0, 4);
         stretch = $urandom_range(16, 160);
         repeat (stretch) begin
            @(negedge clock);
            cyc++;
            if (holds_done != hold_requests) begin
               rsp_stall <= 1'b1;
               repeat (LONG_HOLD) @(negedge clock);
               holds_done++;
            end
            case (mode)
               0:       rsp_stall <= 1'b0;                       // free flowing
               1:       rsp_stall <= ($urandom_range(0, 2) == 0);
               2:       rsp_stall <= ($urandom_range(0, 3) != 0); // mostly stalled
               3:       rsp_stall <= (cyc % 3 == 0);
               default: rsp_stall <= ($urandom_range(0, 7) == 0);
            endcase
         end
      end
   end

   // Hard stop in case the DUT hangs.
   initial begin
      #(RUN_LIMIT);
      $display("TB_ERROR");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------
   initial begin : main_seq
      int          settings;
      int          random_left;
      int          phase_beats;
      int unsigned len, eff, dly;
      int          which;
      int          phase;

      chk           = new();
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_sample_in = '0;
      csr_we        = 1'b0;
      csr_index     = fdl_pkg::REG_LINE_LENGTH;
      csr_wdata     = '0;
      burst_left    = 0;
      gap_max       = 2;
      beats_sent    = 0;
      hold_requests = 0;
      holds_done    = 0;
      settings      = 1;

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // --- directed ---------------------------------------------------
      // Reset config (length 1024, zero delay): output is the beat itself.
      // Req is held off during the clearing pass; the handshake absorbs it.
      send_sample(16'sh7FFF);
      send_sample(16'sh8000);
      send_sample(16'sh0000);
      send_sample(16'shFFFF);

      // Length 0 reads as 2, delay at field max saturates to one sample;
      // write pointer (now 4) is past the new end and must restart.
      wait_idle();
      configure(1, 0, 1, DELAY_FIELD_MAX);
      settings++;
      send_sample(16'sh7FFF);
      send_sample(16'sh8000);
      send_sample(16'sh7FFF);
      send_sample(16'sh8000);

      // Length 1 reads as 2; half-sample delay between the rails rounds up.
      wait_idle();
      configure(1, 1, 1, ONE_Q / 2);
      settings++;
      send_sample(16'sh8000);
      send_sample(16'sh7FFF);
      send_sample(16'sh8000);

      // Length field max clamps to the line depth; largest pure fraction.
      wait_idle();
      configure(1, LEN_FIELD_MAX, 1, ONE_Q - 1);
      settings++;
      send_sample(16'sh7FFF);
      send_sample(16'sh8000);
      send_sample(16'sh1234);

      // One past the depth; exactly the longest legal delay.
      wait_idle();
      configure(1, LINE_MAX + 1, 1, (LINE_MAX - 1) * ONE_Q);
      settings++;
      send_sample(16'sh8000);
      send_sample(16'sh7FFF);
      send_sample(16'shFFFF);

      // Short line over stale contents: old samples stay put. Upper csr
      // bits above the length field are set and must be ignored.
      wait_idle();
      configure(1, 5 | (DELAY_FIELD_MAX & ~LEN_FIELD_MAX), 1, 2 * ONE_Q + 77);
      settings++;
      send_sample(16'sh7FFF);
      send_sample(16'sh8000);
      send_sample(16'sh0001);
      send_sample(16'sh4000);
      send_sample(16'shC000);

      // --- random -----------------------------------------------------
      random_left = RANDOM_BEATS;
      phase = 0;
      while (random_left > 0) begin
         wait_idle();
         case ($urandom_range(0, 8))
            0:       len = 0;
            1:       len = 1;
            2:       len = fdl_pkg::MIN_LENGTH;
            3:       len = LEN_FIELD_MAX;
            4:       len = LINE_MAX;
            5:       len = $urandom_range(0, LEN_FIELD_MAX);
            6, 7:    len = $urandom_range(2, 40);
            default: len = $urandom_range(2, LINE_MAX);
         endcase
         eff = (len < fdl_pkg::MIN_LENGTH) ? fdl_pkg::MIN_LENGTH :
               (len > LINE_MAX) ? LINE_MAX : len;
         case ($urandom_range(0, 6))
            0:       dly = 0;
            1:       dly = DELAY_FIELD_MAX;
            2:       dly = $urandom_range(0, ONE_Q - 1);
            3:       dly = (eff - 1) * ONE_Q;
            4:       dly = $urandom_range(0, DELAY_FIELD_MAX);
            default: dly = $urandom_range(0, (eff - 1) * ONE_Q);
         endcase
         which = $urandom_range(0, 3);
         configure(which != 1, len, which != 0, dly);
         settings++;

         // sender character per phase: gapless, light or heavy gaps
         case ($urandom_range(0, 2))
            0:       gap_max = 0;
            1:       gap_max = 2;
            default: gap_max = 8;
         endcase

         // long receiver hold early on and now and then after
         if (phase == 1 || $urandom_range(0, 5) == 0) begin
            gap_max = 0;
            hold_requests++;
         end

         phase_beats = $urandom_range(20, 120);
         if (phase_beats > random_left) phase_beats = random_left;
         repeat (phase_beats) send_sample(pick_sample());
         random_left -= phase_beats;
         phase++;
      end

      // --- wind down --------------------------------------------------
      wait_idle();
      repeat (10) @(negedge clock);

      $display("Run: %0d samples over %0d line settings, %0d outputs compared.",
               beats_sent, settings, chk.checked);
      $display("Included clamped lengths, saturated delays and %0d long output holds.",
               holds_done);
      if (chk.outstanding() != 0)
         $error("sample_out: %0d expected outputs never arrived", chk.outstanding());
      if (chk.mismatches == 0 && chk.outstanding() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

// ===== fractional_delay_line.f =====
+incdir+hw/rtl
hw/rtl/fdl_pkg.sv
hw/rtl/fractional_delay_line.sv
tb/tb_top.sv
